@@ sv/ckab_pkg.sv @@
// Shared types and constants for the chroma key alpha blend block.
// Used by every module of the block; depends on nothing else.
package ckab_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned COLOR_W = 3 * CHAN_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = COLOR_W;
    localparam int unsigned S_TDATA_W = 8 * CHAN_W;
    localparam int unsigned M_TDATA_W = 4 * CHAN_W;
    localparam int unsigned M_TUSER_W = 2;

    localparam logic [CHAN_W-1:0] OPAQUE = 8'hff;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LO        = 3'd0,
        REG_KEY_HI        = 3'd1,
        REG_MASK_RGB      = 3'd2,
        REG_WT_INSIDE     = 3'd3,
        REG_WT_OUTSIDE    = 3'd4,
        REG_SRC_HAS_ALPHA = 3'd5,
        REG_DST_HAS_ALPHA = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] key_lo;
        logic [COLOR_W-1:0] key_hi;
        logic [COLOR_W-1:0] mask_rgb;
        logic [CHAN_W-1:0]  wt_inside;
        logic [CHAN_W-1:0]  wt_outside;
        logic               src_has_alpha;
        logic               dst_has_alpha;
    } t_cfg;

    // Field order matches the input beat, last member in the lowest bits.
    typedef struct packed {
        logic [CHAN_W-1:0] dst_alpha;
        logic [CHAN_W-1:0] dst_blue;
        logic [CHAN_W-1:0] dst_green;
        logic [CHAN_W-1:0] dst_red;
        logic [CHAN_W-1:0] src_alpha;
        logic [CHAN_W-1:0] src_blue;
        logic [CHAN_W-1:0] src_green;
        logic [CHAN_W-1:0] src_red;
    } t_pixel_pair;

    typedef struct packed {
        logic              in_key_range;
        logic              masked;
        logic [CHAN_W-1:0] out_alpha;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
    } t_result;

    // True when a channel lies inside its low/high key bounds.
    function automatic logic in_band(input logic [CHAN_W-1:0] v,
                                     input logic [CHAN_W-1:0] lo,
                                     input logic [CHAN_W-1:0] hi);
        in_band = (lo <= v) && (v <= hi);
    endfunction

endpackage

@@ sv/ckab_cfg.sv @@
// Configuration register file for the chroma key alpha blend block.
// Depends on ckab_pkg for the register index codes and the t_cfg struct.
module ckab_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [ckab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ckab_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ckab_pkg::t_cfg                 o_cfg
);
    import ckab_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_KEY_LO:        n_cfg.key_lo        = i_cfg_data[COLOR_W-1:0];
                REG_KEY_HI:        n_cfg.key_hi        = i_cfg_data[COLOR_W-1:0];
                REG_MASK_RGB:      n_cfg.mask_rgb      = i_cfg_data[COLOR_W-1:0];
                REG_WT_INSIDE:     n_cfg.wt_inside     = i_cfg_data[CHAN_W-1:0];
                REG_WT_OUTSIDE:    n_cfg.wt_outside    = i_cfg_data[CHAN_W-1:0];
                REG_SRC_HAS_ALPHA: n_cfg.src_has_alpha = i_cfg_data[0];
                REG_DST_HAS_ALPHA: n_cfg.dst_has_alpha = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_lo        <= '0;
            r_cfg.key_hi        <= '1;
            r_cfg.mask_rgb      <= '0;
            r_cfg.wt_inside     <= OPAQUE;
            r_cfg.wt_outside    <= OPAQUE;
            r_cfg.src_has_alpha <= 1'b0;
            r_cfg.dst_has_alpha <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/ckab_mix.sv @@
// One channel of the blend: dst + w*(src-dst)/256, quotient truncated toward zero.
// Depends on ckab_pkg for the channel width.
module ckab_mix (
    input  logic [ckab_pkg::CHAN_W-1:0] i_dst,
    input  logic [ckab_pkg::CHAN_W-1:0] i_src,
    input  logic [ckab_pkg::CHAN_W-1:0] i_weight,
    output logic [ckab_pkg::CHAN_W-1:0] o_mix
);
    import ckab_pkg::*;

    logic signed [CHAN_W:0]       diff;
    logic signed [2*CHAN_W+1:0]   prod;
    logic signed [2*CHAN_W+1:0]   biased;
    logic signed [CHAN_W+1:0]     step;

    always_comb begin
        diff = $signed({1'b0, i_src}) - $signed({1'b0, i_dst});
        prod = $signed({1'b0, i_weight}) * diff;
        // A negative product needs a bias of 255 so the shift rounds toward zero.
        biased = prod[2*CHAN_W+1] ? prod + (2*CHAN_W+2)'(OPAQUE) : prod;
        step = (CHAN_W+2)'(biased >>> CHAN_W);
        o_mix = i_dst + step[CHAN_W-1:0];
    end

endmodule

@@ sv/ckab_core.sv @@
// Per-pixel datapath: mask match, chroma range test, weight pick and four blends.
// Depends on ckab_pkg and instantiates ckab_mix once per channel.
module ckab_core (
    input  ckab_pkg::t_cfg        i_cfg,
    input  ckab_pkg::t_pixel_pair i_pix,
    output ckab_pkg::t_result     o_res
);
    import ckab_pkg::*;

    logic [COLOR_W-1:0] src_rgb;
    logic               hit_mask;
    logic               keyed;
    logic [CHAN_W-1:0]  weight;
    logic [CHAN_W-1:0]  alpha_src;
    logic [CHAN_W-1:0]  mix_r;
    logic [CHAN_W-1:0]  mix_g;
    logic [CHAN_W-1:0]  mix_b;
    logic [CHAN_W-1:0]  mix_a;

    assign src_rgb  = {i_pix.src_red, i_pix.src_green, i_pix.src_blue};
    assign hit_mask = (i_cfg.mask_rgb != '0) && (src_rgb == i_cfg.mask_rgb);
    assign keyed =
        in_band(i_pix.src_red,   i_cfg.key_lo[23:16], i_cfg.key_hi[23:16]) &&
        in_band(i_pix.src_green, i_cfg.key_lo[15:8],  i_cfg.key_hi[15:8])  &&
        in_band(i_pix.src_blue,  i_cfg.key_lo[7:0],   i_cfg.key_hi[7:0]);
    assign weight    = keyed ? i_cfg.wt_inside : i_cfg.wt_outside;
    assign alpha_src = i_cfg.src_has_alpha ? i_pix.src_alpha : OPAQUE;

    ckab_mix u_mix_r (.i_dst(i_pix.dst_red),   .i_src(i_pix.src_red),
                      .i_weight(weight), .o_mix(mix_r));
    ckab_mix u_mix_g (.i_dst(i_pix.dst_green), .i_src(i_pix.src_green),
                      .i_weight(weight), .o_mix(mix_g));
    ckab_mix u_mix_b (.i_dst(i_pix.dst_blue),  .i_src(i_pix.src_blue),
                      .i_weight(weight), .o_mix(mix_b));
    ckab_mix u_mix_a (.i_dst(i_pix.dst_alpha), .i_src(alpha_src),
                      .i_weight(weight), .o_mix(mix_a));

    always_comb begin
        o_res.masked       = hit_mask;
        o_res.in_key_range = keyed;
        o_res.out_red      = hit_mask ? i_pix.dst_red   : mix_r;
        o_res.out_green    = hit_mask ? i_pix.dst_green : mix_g;
        o_res.out_blue     = hit_mask ? i_pix.dst_blue  : mix_b;
        o_res.out_alpha    = (hit_mask || !i_cfg.dst_has_alpha) ? i_pix.dst_alpha : mix_a;
    end

endmodule

@@ sv/chroma_key_alpha_blend.sv @@
// Top level of the chroma key alpha blend block: stream ports, config port, pipeline.
// Depends on ckab_pkg and instantiates ckab_cfg and ckab_core.
//
// The block blends a stream of source pixels into the matching destination
// pixels, one pixel pair per input beat and one result per output beat. It
// sustains one pixel per clock while the output is not stalled: a beat taken
// on the slave side lands in an input register, the blend runs between that
// register and the output register, and the result is offered on the master
// side from the output register. A new beat can still be taken while a
// finished result waits for the downstream side, as long as the input
// register is empty; ready back-pressure travels through the two stages in
// the same cycle. Configuration writes are always accepted (o_cfg_ready is
// tied high) and should only be issued while no pixel is in flight, since
// the datapath reads the registers live. Writes to index 7 are ignored.
module chroma_key_alpha_blend (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input beat, tdata from bit 0 up: src_red, src_green, src_blue, src_alpha,
    // dst_red, dst_green, dst_blue, dst_alpha (8 bits each).
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ckab_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result beat, tdata from bit 0 up: out_red, out_green, out_blue, out_alpha.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ckab_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser from bit 0 up: masked, in_key_range.
    output logic [ckab_pkg::M_TUSER_W-1:0]  m_tuser,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ckab_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ckab_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ckab_pkg::*;

    t_cfg        cfg;
    t_pixel_pair r_pix;
    logic        r_pix_valid;
    t_result     core_res;
    t_result     r_res;
    logic        r_res_valid;
    logic        res_ready;
    logic        pix_ready;

    // The config register file never stalls a write.
    assign o_cfg_ready = 1'b1;

    ckab_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Each stage may load when it is empty or when the stage after it moves on.
    assign res_ready = !r_res_valid || m_tready;
    assign pix_ready = !r_pix_valid || res_ready;
    assign s_tready  = pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (pix_ready) begin
                r_pix_valid <= s_tvalid;
            end
            if (res_ready) begin
                r_res_valid <= r_pix_valid;
            end
        end
    end

    // Payload registers load only with a beat behind them; no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_tvalid && pix_ready) begin
            r_pix <= t_pixel_pair'(s_tdata);
        end
        if (r_pix_valid && res_ready) begin
            r_res <= core_res;
        end
    end

    ckab_core u_core (
        .i_cfg (cfg),
        .i_pix (r_pix),
        .o_res (core_res)
    );

    assign m_tvalid = r_res_valid;
    assign m_tdata  = {r_res.out_alpha, r_res.out_blue, r_res.out_green, r_res.out_red};
    assign m_tuser  = {r_res.in_key_range, r_res.masked};

endmodule

@@ sv/ckab_checker.sv @@
// Port-level checks for chroma_key_alpha_blend, attached by the bind below.
// Depends on ckab_pkg for the port widths.
module ckab_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ckab_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [ckab_pkg::M_TUSER_W-1:0]  m_tuser
);
    import ckab_pkg::*;

    // A stalled result beat stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // With the output side draining, the input side is never stalled.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind chroma_key_alpha_blend ckab_checker u_ckab_checker (.*);
